### rtl/core/rcf_pkg.sv
package rcf_pkg;

    // Number of colour channels and the width of one duty value.
    localparam int unsigned ChannelCount = 3;
    localparam int unsigned DutyWidth    = 8;
    localparam int unsigned StepWidth    = 5;

    // Differences up to StepSpan move by one count per tick; larger ones by
    // (magnitude / StepSpan) + 1. A channel within SnapWindow snaps to its goal.
    localparam int unsigned StepSpan   = 20;
    localparam int unsigned SnapWindow = 13;

    // Reciprocal of StepSpan as a 12-bit fraction; exact over 0..255.
    localparam int unsigned RecipShift = 12;
    localparam logic [7:0]  RecipStep  = 8'd205;

    // Action codes carried by an input transfer; code 3 is ignored.
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_FADE = 2'd1;
    localparam logic [1:0] ACT_SET  = 2'd2;

    typedef struct packed {
        logic [1:0]           action;
        logic [DutyWidth-1:0] red_target;
        logic [DutyWidth-1:0] green_target;
        logic [DutyWidth-1:0] blue_target;
    } t_in_item;

    typedef struct packed {
        logic [DutyWidth-1:0] red_duty;
        logic [DutyWidth-1:0] green_duty;
        logic [DutyWidth-1:0] blue_duty;
        logic                 settled;
    } t_out_item;

    // Per-channel commands for the cycle in which one item is processed.
    // At most one member is high in any cycle.
    typedef struct packed {
        logic tick;
        logic first_fade;
        logic plan;
        logic set_now;
    } t_chan_ctl;

endpackage

### rtl/core/rcf_channel.sv
module rcf_channel
    import rcf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_chan_ctl            i_ctl,
    input  logic [DutyWidth-1:0] i_want,
    output logic [DutyWidth-1:0] o_next_duty,
    output logic                 o_next_at_goal
);

    logic [DutyWidth-1:0]        r_duty;
    logic [DutyWidth-1:0]        r_goal;
    logic [DutyWidth-1:0]        r_prior;
    logic signed [StepWidth-1:0] r_step;

    logic [DutyWidth-1:0]        n_duty;
    logic [DutyWidth-1:0]        n_goal;
    logic [DutyWidth-1:0]        n_prior;
    logic signed [StepWidth-1:0] n_step;

    logic [DutyWidth-1:0]        moved;
    logic [DutyWidth:0]          gap;
    logic [DutyWidth-1:0]        gap_mag;
    logic [DutyWidth:0]          diff;
    logic [DutyWidth-1:0]        diff_mag;
    logic [2*DutyWidth-1:0]      recip_prod;
    logic [StepWidth-2:0]        step_mag;

    // Tick: add the signed step modulo 256, then snap once close enough.
    always_comb begin
        moved   = r_duty + DutyWidth'({{(DutyWidth-StepWidth){r_step[StepWidth-1]}}, r_step});
        gap     = {1'b0, moved} - {1'b0, r_goal};
        gap_mag = gap[DutyWidth] ? DutyWidth'(-gap) : gap[DutyWidth-1:0];
    end

    // Fade plan: step size from the difference between new and previous goal.
    always_comb begin
        diff       = {1'b0, i_want} - {1'b0, r_prior};
        diff_mag   = diff[DutyWidth] ? DutyWidth'(-diff) : diff[DutyWidth-1:0];
        recip_prod = diff_mag * RecipStep;
        if (diff_mag <= DutyWidth'(StepSpan)) begin
            step_mag = (StepWidth-1)'(1);
        end else begin
            step_mag = recip_prod[RecipShift +: (StepWidth-1)] + (StepWidth-1)'(1);
        end
    end

    always_comb begin
        n_duty  = r_duty;
        n_goal  = r_goal;
        n_prior = r_prior;
        n_step  = r_step;
        if (i_ctl.tick && (r_duty != r_goal)) begin
            n_duty = (gap_mag <= DutyWidth'(SnapWindow)) ? r_goal : moved;
        end
        if (i_ctl.first_fade) begin
            n_duty  = i_want;
            n_prior = i_want;
        end
        if (i_ctl.plan) begin
            n_goal  = i_want;
            n_prior = i_want;
            if (diff != '0) begin
                n_step = diff[DutyWidth] ? -$signed({1'b0, step_mag})
                                         : $signed({1'b0, step_mag});
            end
        end
        if (i_ctl.set_now) begin
            n_duty = i_want;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty  <= '0;
            r_goal  <= '0;
            r_prior <= '0;
            r_step  <= '0;
        end else begin
            r_duty  <= n_duty;
            r_goal  <= n_goal;
            r_prior <= n_prior;
            r_step  <= n_step;
        end
    end

    assign o_next_duty    = n_duty;
    assign o_next_at_goal = (n_duty == n_goal);

endmodule

### rtl/core/rgb_pwm_color_fader_core.sv
// An input item passes the input register and then the result register to the output.
// Throughput: one item per cycle while the output is not stalled; the fader state is
// updated in the cycle that processes the item, so the next item can follow immediately.
// Reset (i_rst_n low at a clock edge): duties, goals, previous goals and steps clear to
// zero, ticking is disabled and both the input and output registers are emptied.
module rgb_pwm_color_fader_core
    import rcf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    // The block is a single registered pass. An input register captures each
    // transfer; when it is processed, the three channel units compute the new
    // state from it, commit that state, and the result register captures the
    // reported duties. The input register doubles as a skid stage: while a
    // finished result waits at the output, one further item is still taken.

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      r_ticking;
    logic      n_ticking;

    logic      proc_fire;
    t_chan_ctl chan_ctl;

    logic [DutyWidth-1:0] want     [ChannelCount];
    logic [DutyWidth-1:0] new_duty [ChannelCount];
    logic [ChannelCount-1:0] at_goal;

    // An item is processed when the result register is free or is being
    // emptied in the same cycle.
    assign proc_fire  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc_fire;

    // Decode the held action into per-channel commands. Ticks are ignored
    // until the first fade request has enabled ticking; the first fade loads
    // the duties directly and only later fades plan a new step.
    always_comb begin
        chan_ctl  = '0;
        n_ticking = r_ticking;
        if (proc_fire) begin
            unique case (r_in_item.action)
                ACT_TICK: begin
                    chan_ctl.tick = r_ticking;
                end
                ACT_FADE: begin
                    if (r_ticking) begin
                        chan_ctl.plan = 1'b1;
                    end else begin
                        chan_ctl.first_fade = 1'b1;
                        n_ticking           = 1'b1;
                    end
                end
                ACT_SET: begin
                    chan_ctl.set_now = 1'b1;
                end
                default: begin
                    // Unused action code: the state holds and the current duties are reported.
                end
            endcase
        end
    end

    assign want[0] = r_in_item.red_target;
    assign want[1] = r_in_item.green_target;
    assign want[2] = r_in_item.blue_target;

    for (genvar g = 0; g < ChannelCount; g++) begin : g_chan
        rcf_channel u_channel (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (chan_ctl),
            .i_want         (want[g]),
            .o_next_duty    (new_duty[g]),
            .o_next_at_goal (at_goal[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ticking   <= 1'b0;
        end else begin
            r_ticking <= n_ticking;
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (proc_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (proc_fire) begin
            r_out_item.red_duty   <= new_duty[0];
            r_out_item.green_duty <= new_duty[1];
            r_out_item.blue_duty  <= new_duty[2];
            r_out_item.settled    <= &at_goal;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import rcf_pkg::*;

    // The block ignores action code 3; the package gives it no name.
    localparam logic [1:0] ACT_IGNORED = 2'd3;

    localparam int unsigned RANDOM_ITEMS = 1950;
    localparam int unsigned IDLE_PERCENT = 31;
    localparam int unsigned HOLD_CYCLES  = 120;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned DIRECTED_ROWS = 25;

    typedef struct packed {
        t_in_item  stim;
        logic      typed;
        t_out_item want;
    } t_directed_row;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    // The fader's own view of the state, kept alongside the block.
    logic [7:0]        cur_duty   [3];
    logic [7:0]        goal_duty  [3];
    logic [7:0]        last_goal  [3];
    logic signed [4:0] chan_step  [3];
    logic              fading_live;

    t_out_item pending_duties [$];
    t_out_item arrived_duty;

    int mismatch_count;
    int results_checked;
    int tick_count;
    int fade_count;
    int set_count;
    int ignored_count;

    // Idling is switched off by the stimulus for a stretch, and the long
    // receiver hold-off is requested by it once.
    logic calm;
    logic hold_request;

    // Directed rows. Where a row's result follows plainly from the reset
    // state, a set or the first fade, it is typed in; all other rows use the predictor.
    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        // Ticks before the first fade request change nothing.
        '{'{ACT_TICK, 8'h00, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1}},
        '{'{ACT_TICK, 8'hff, 8'hff, 8'hff}, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1}},
        // The spare action code only reports the duties.
        '{'{ACT_IGNORED, 8'haa, 8'h55, 8'hff}, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1}},
        '{'{ACT_SET, 8'hff, 8'h00, 8'h80}, 1'b1, '{8'hff, 8'h00, 8'h80, 1'b0}},
        '{'{ACT_TICK, 8'h12, 8'h34, 8'h56}, 1'b1, '{8'hff, 8'h00, 8'h80, 1'b0}},
        '{'{ACT_SET, 8'h00, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1}},
        // The first fade loads the duties; the goals stay at zero.
        '{'{ACT_FADE, 8'h0a, 8'hc8, 8'hff}, 1'b1, '{8'h0a, 8'hc8, 8'hff, 1'b0}},
        // Zero steps off target: red is within the snap window, the rest stay.
        '{'{ACT_TICK, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{ACT_TICK, 8'hff, 8'hff, 8'hff}, 1'b0, '0},
        // Largest rise, a middle rise, and no change on blue.
        '{'{ACT_FADE, 8'hff, 8'hff, 8'hff}, 1'b0, '0},
        '{'{ACT_TICK, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{ACT_TICK, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{ACT_TICK, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{ACT_TICK, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{ACT_TICK, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        // Largest fall.
        '{'{ACT_FADE, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{ACT_TICK, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{ACT_TICK, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{ACT_TICK, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        // Differences of exactly 20 and 21 either way, around the step span.
        '{'{ACT_FADE, 8'h14, 8'h15, 8'h00}, 1'b0, '0},
        '{'{ACT_FADE, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{ACT_TICK, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{ACT_SET, 8'h80, 8'h80, 8'h80}, 1'b0, '0},
        '{'{ACT_TICK, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{ACT_IGNORED, 8'h00, 8'h00, 8'h00}, 1'b0, '0}
    };

    rgb_pwm_color_fader_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Applies one item to the predicted fader state and returns the result
    // that the block should report for it.
    function automatic t_out_item fader_advance(input t_in_item it);
        logic [7:0]  want [3];
        int          diff;
        int          mag;
        int          gap;
        int          stride;
        t_out_item   res;
        want[0] = it.red_target;
        want[1] = it.green_target;
        want[2] = it.blue_target;
        case (it.action)
            ACT_TICK: begin
                if (fading_live) begin
                    for (int c = 0; c < 3; c++) begin
                        if (cur_duty[c] != goal_duty[c]) begin
                            cur_duty[c] = cur_duty[c] + {{3{chan_step[c][4]}}, chan_step[c]};
                            gap = int'(cur_duty[c]) - int'(goal_duty[c]);
                            if (gap < 0) gap = -gap;
                            if (gap <= int'(SnapWindow)) cur_duty[c] = goal_duty[c];
                        end
                    end
                end
            end
            ACT_FADE: begin
                if (!fading_live) begin
                    // The goals and steps are left as they were.
                    for (int c = 0; c < 3; c++) begin
                        cur_duty[c]  = want[c];
                        last_goal[c] = want[c];
                    end
                    fading_live = 1'b1;
                end else begin
                    for (int c = 0; c < 3; c++) begin
                        diff = int'(want[c]) - int'(last_goal[c]);
                        goal_duty[c] = want[c];
                        last_goal[c] = want[c];
                        if (diff != 0) begin
                            mag    = (diff < 0) ? -diff : diff;
                            stride = (mag <= int'(StepSpan)) ? 1 : mag / int'(StepSpan) + 1;
                            chan_step[c] = 5'((diff < 0) ? -stride : stride);
                        end
                    end
                end
            end
            ACT_SET: begin
                for (int c = 0; c < 3; c++) cur_duty[c] = want[c];
            end
            default: ;
        endcase
        res.red_duty   = cur_duty[0];
        res.green_duty = cur_duty[1];
        res.blue_duty  = cur_duty[2];
        res.settled    = (cur_duty[0] == goal_duty[0]) && (cur_duty[1] == goal_duty[1])
                         && (cur_duty[2] == goal_duty[2]);
        return res;
    endfunction

    // Picks a fade target relative to the previous one, leaning on the step
    // boundaries, on no change at all and on the ends of the range.
    function automatic logic [7:0] pick_goal(input logic [7:0] prior);
        int roll;
        roll = $urandom_range(99);
        if (roll < 30) return 8'($urandom);
        if (roll < 55) return prior + 8'($urandom_range(40)) - 8'd20;
        if (roll < 70) return prior;
        if (roll < 85) return {8{1'($urandom_range(1))}};
        if (roll < 92) return $urandom_range(1) ? prior + 8'd20 : prior - 8'd20;
        return $urandom_range(1) ? prior + 8'd21 : prior - 8'd21;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Offers one item, waits for its transfer and records what it should give.
    task automatic send_item(input t_in_item it, input logic typed, input t_out_item typed_res);
        t_out_item predicted;
        @(negedge clk);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted = fader_advance(it);
        pending_duties.push_back(typed ? typed_res : predicted);
        case (it.action)
            ACT_TICK: tick_count++;
            ACT_FADE: fade_count++;
            ACT_SET:  set_count++;
            default:  ignored_count++;
        endcase
    endtask

    // Receiver: random back-pressure, apart from the calm stretch and the
    // single long hold-off, which is counted out here in its own cycles.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                out_ready    <= 1'b0;
                hold_request = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else begin
                out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Every result transfer is checked against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_duties.size() == 0) begin
                report_mismatch("result with nothing expected", int'(out_item), 0);
            end else begin
                arrived_duty = pending_duties.pop_front();
                if (out_item.red_duty !== arrived_duty.red_duty)
                    report_mismatch("red_duty", int'(out_item.red_duty),
                                    int'(arrived_duty.red_duty));
                if (out_item.green_duty !== arrived_duty.green_duty)
                    report_mismatch("green_duty", int'(out_item.green_duty),
                                    int'(arrived_duty.green_duty));
                if (out_item.blue_duty !== arrived_duty.blue_duty)
                    report_mismatch("blue_duty", int'(out_item.blue_duty),
                                    int'(arrived_duty.blue_duty));
                if (out_item.settled !== arrived_duty.settled)
                    report_mismatch("settled", int'(out_item.settled),
                                    int'(arrived_duty.settled));
                results_checked++;
            end
        end
    end

    initial begin
        #2ms;
        $display("FAIL");
        $finish;
    end

    initial begin
        t_in_item stim;
        int       counted;
        int       burst_left;
        int       roll;
        logic     hold_fired;

        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        calm         = 1'b0;
        hold_request = 1'b0;
        hold_fired   = 1'b0;
        counted      = 0;
        burst_left   = 0;
        mismatch_count  = 0;
        results_checked = 0;
        tick_count    = 0;
        fade_count    = 0;
        set_count     = 0;
        ignored_count = 0;
        fading_live   = 1'b0;
        for (int c = 0; c < 3; c++) begin
            cur_duty[c]  = '0;
            goal_duty[c] = '0;
            last_goal[c] = '0;
            chan_step[c] = '0;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_item(directed_rows[r].stim, directed_rows[r].typed, directed_rows[r].want);

        // Random part: bursts that open with a fade request and carry on with
        // ticks, broken now and then by an immediate set or the spare code.
        while (counted < RANDOM_ITEMS) begin
            roll = $urandom_range(99);
            stim = '{ACT_TICK, 8'($urandom), 8'($urandom), 8'($urandom)};
            if (burst_left == 0) begin
                stim.action       = ACT_FADE;
                stim.red_target   = pick_goal(last_goal[0]);
                stim.green_target = pick_goal(last_goal[1]);
                stim.blue_target  = pick_goal(last_goal[2]);
                burst_left        = $urandom_range(1, 30);
            end else begin
                burst_left--;
                if (roll < 4)
                    stim.action = ACT_IGNORED;
                else if (roll < 9)
                    stim.action = ACT_SET;
            end
            send_item(stim, 1'b0, '0);
            if (stim.action != ACT_IGNORED) counted++;
            calm = (counted >= 1000) && (counted < 1300);
            if (counted >= 600 && !hold_fired) begin
                hold_request = 1'b1;
                hold_fired   = 1'b1;
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_duties.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d ticks, %0d fade requests, %0d sets and %0d spare-code items.",
                 tick_count, fade_count, set_count, ignored_count);
        $display("Compared %0d results; %0d mismatches.", results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
